@@ sv/cnv3_pkg.sv @@
// Shared constants, types and register codes of the 3x3 convolution block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cnv3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int KROW_W     = 24;
    localparam int SCALE_W    = 24;
    localparam int DIM_CFG_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int TAPS       = 9;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int SUM_W      = PROD_W + 4;
    localparam int FRAC_W     = 16;
    localparam int SCALED_W   = SUM_W + SCALE_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KROW_TOP = 3'd0,
        REG_KROW_MID = 3'd1,
        REG_KROW_BOT = 3'd2,
        REG_SCALE    = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic [KROW_W-1:0]  krow_top;
        logic [KROW_W-1:0]  krow_mid;
        logic [KROW_W-1:0]  krow_bot;
        logic [SCALE_W-1:0] scale;
        logic [COL_W:0]     width;
        logic [ROW_W:0]     height;
    } t_cfg;

endpackage

`default_nettype wire

@@ sv/conv3x3_pixel_stream.sv @@
// Top level of the 3x3 convolution filter over a raster pixel stream.
// Depends on cnv3_pkg, cnv3_scan, cnv3_window and cnv3_mac.
//
// Pixels enter in raster order on the i_valid / o_ready channel, one word per
// pixel. Each interior pixel produces one result word on o_valid / i_ready with
// its row, column, filtered value and an end-of-frame flag; border pixels
// produce nothing. The filter sums kernel byte times window pixel over the
// 3x3 window, scales by an unsigned Q8.16 factor and saturates to 0..255.
// Registers are written on the i_cfg_valid / o_cfg_ready channel, which is
// always ready; write them only while no pixel is in flight.
// A pixel can be accepted in every clock cycle while fewer than eight results are
// queued or in the pipeline. The pixel passes the line store read, then window,
// products, sum, scaling and the result queue before its result is presented. The
// line store is a single memory read and written once per pixel, one column apart.
// An eight-word result queue absorbs stalls of the receiver; input is held off
// once eight results are queued or in the pipeline.
// Reset clears the position counters, the window and the queue and loads the
// default registers. The line store is not cleared; the first two rows of a
// frame fill it before any result depends on it.
`default_nettype none

module conv3x3_pixel_stream (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [cnv3_pkg::PIX_W-1:0]      i_pixel,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cnv3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cnv3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [cnv3_pkg::POS_W-1:0]           o_out_row,
    output logic [cnv3_pkg::POS_W-1:0]           o_out_col,
    output logic [cnv3_pkg::PIX_W-1:0]           o_out_value,
    output logic                                 o_last_of_frame
);
    import cnv3_pkg::*;

    logic [KROW_W-1:0]    r_krow_top;
    logic [KROW_W-1:0]    r_krow_mid;
    logic [KROW_W-1:0]    r_krow_bot;
    logic [SCALE_W-1:0]   r_scale;
    logic [DIM_CFG_W-1:0] r_width;
    logic [DIM_CFG_W-1:0] r_height;
    t_cfg                 cfg;
    logic                 acc;
    logic [COL_W-1:0]     addr;
    logic                 emit;
    t_meta                scan_meta;
    logic                 win_valid;
    t_meta                win_meta;
    t_pix                 win [TAPS];
    logic                 pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow_top <= KROW_W'(0);
            r_krow_mid <= KROW_W'(256);
            r_krow_bot <= KROW_W'(0);
            r_scale    <= SCALE_W'(65536);
            r_width    <= DIM_CFG_W'(640);
            r_height   <= DIM_CFG_W'(480);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KROW_TOP: r_krow_top <= i_cfg_data[KROW_W-1:0];
                REG_KROW_MID: r_krow_mid <= i_cfg_data[KROW_W-1:0];
                REG_KROW_BOT: r_krow_bot <= i_cfg_data[KROW_W-1:0];
                REG_SCALE:    r_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_WIDTH:    r_width    <= i_cfg_data[DIM_CFG_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[DIM_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.krow_top = r_krow_top;
        cfg.krow_mid = r_krow_mid;
        cfg.krow_bot = r_krow_bot;
        cfg.scale    = r_scale;
        if (r_width < DIM_CFG_W'(3)) begin
            cfg.width = (COL_W+1)'(3);
        end else if (32'(r_width) > MAX_WIDTH) begin
            cfg.width = (COL_W+1)'(MAX_WIDTH);
        end else begin
            cfg.width = (COL_W+1)'(r_width);
        end
        if (r_height < DIM_CFG_W'(3)) begin
            cfg.height = (ROW_W+1)'(3);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            cfg.height = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            cfg.height = (ROW_W+1)'(r_height);
        end
    end

    cnv3_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pop   (pop),
        .o_acc   (acc),
        .o_addr  (addr),
        .o_emit  (emit),
        .o_meta  (scan_meta)
    );

    cnv3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_addr  (addr),
        .i_px    (i_pixel),
        .i_emit  (emit),
        .i_meta  (scan_meta),
        .o_valid (win_valid),
        .o_meta  (win_meta),
        .o_win   (win)
    );

    cnv3_mac u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (win_valid),
        .i_meta          (win_meta),
        .i_win           (win),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_pop           (pop),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_value     (o_out_value),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

@@ sv/cnv3_scan.sv @@
// Raster position counters, result credit counter and input handshake.
// Depends on cnv3_pkg.
`default_nettype none

module cnv3_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cnv3_pkg::t_cfg              i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_pop,
    output logic                             o_acc,
    output logic [cnv3_pkg::COL_W-1:0]       o_addr,
    output logic                             o_emit,
    output cnv3_pkg::t_meta                  o_meta
);
    import cnv3_pkg::*;

    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic                col_wrap;
    logic [COL_W-1:0]    c0;
    logic [ROW_W:0]      row_pre;
    logic [ROW_W-1:0]    r0;
    logic [COL_W:0]      col_nx;
    logic [ROW_W:0]      row_nx;

    always_comb begin
        col_wrap = {1'b0, r_col} >= i_cfg.width;
        c0       = col_wrap ? '0 : r_col;
        row_pre  = {1'b0, r_row} + {{ROW_W{1'b0}}, col_wrap};
        r0       = (row_pre >= i_cfg.height) ? '0 : row_pre[ROW_W-1:0];
        col_nx   = {1'b0, c0} + (COL_W+1)'(1);
        row_nx   = {1'b0, r0} + (ROW_W+1)'(1);
        if (col_nx >= i_cfg.width) begin
            n_col = '0;
            n_row = (row_nx >= i_cfg.height) ? '0 : row_nx[ROW_W-1:0];
        end else begin
            n_col = col_nx[COL_W-1:0];
            n_row = r0;
        end
    end

    assign o_ready  = r_credit < CREDIT_W'(FIFO_DEPTH);
    assign o_acc    = i_valid && o_ready;
    assign o_addr   = c0;
    assign o_emit   = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    assign o_meta.row  = POS_W'(r0 - ROW_W'(1));
    assign o_meta.col  = POS_W'(c0 - COL_W'(1));
    assign o_meta.last = ({1'b0, r0} == i_cfg.height - (ROW_W+1)'(1))
                      && ({1'b0, c0} == i_cfg.width - (COL_W+1)'(1));

    always_comb begin
        n_credit = r_credit;
        if (o_acc && o_emit) begin
            n_credit = n_credit + CREDIT_W'(1);
        end
        if (i_pop) begin
            n_credit = n_credit - CREDIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
            if (o_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(FIFO_DEPTH))
        else $error("result credit count exceeds queue depth");

    a_credit_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_acc && o_emit && !i_pop) |=> (r_credit != '0))
        else $error("accepted interior pixel did not reserve a queue slot");

endmodule

`default_nettype wire

@@ sv/cnv3_window.sv @@
// Line store memory with read-modify-write per column, and the 3x3 window.
// Depends on cnv3_pkg.
`default_nettype none

module cnv3_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_acc,
    input  wire logic [cnv3_pkg::COL_W-1:0]  i_addr,
    input  wire cnv3_pkg::t_pix              i_px,
    input  wire logic                        i_emit,
    input  wire cnv3_pkg::t_meta             i_meta,
    output logic                             o_valid,
    output cnv3_pkg::t_meta                  o_meta,
    output cnv3_pkg::t_pix                   o_win [cnv3_pkg::TAPS]
);
    import cnv3_pkg::*;

    // Each entry holds the row two above in the upper byte, the row above in the lower.
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rdata;
    logic               r_s1_valid;
    logic               r_s1_emit;
    logic [COL_W-1:0]   r_s1_addr;
    t_pix               r_s1_px;
    t_meta              r_s1_meta;
    t_pix               r_win [TAPS];
    logic               r_s2_valid;
    t_meta              r_s2_meta;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rdata <= r_line_mem[i_addr];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_addr] <= {r_rdata[PIX_W-1:0], r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_valid <= i_acc;
            r_s2_valid <= r_s1_valid && r_s1_emit;
            if (r_s1_valid) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_rdata[2*PIX_W-1:PIX_W];
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= r_rdata[PIX_W-1:0];
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_emit <= i_emit;
            r_s1_addr <= i_addr;
            r_s1_px   <= i_px;
            r_s1_meta <= i_meta;
        end
        if (r_s1_valid) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_meta  = r_s2_meta;
    assign o_win   = r_win;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_s1_valid) |-> (i_addr != r_s1_addr))
        else $error("line store read and write hit the same column");

endmodule

`default_nettype wire

@@ sv/cnv3_mac.sv @@
// Multiply-accumulate and scaling pipeline with the output result queue.
// Depends on cnv3_pkg.
`default_nettype none

module cnv3_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cnv3_pkg::t_cfg              i_cfg,
    input  wire logic                        i_valid,
    input  wire cnv3_pkg::t_meta             i_meta,
    input  wire cnv3_pkg::t_pix              i_win [cnv3_pkg::TAPS],
    input  wire logic                        i_ready,
    output logic                             o_valid,
    output logic                             o_pop,
    output logic [cnv3_pkg::POS_W-1:0]       o_out_row,
    output logic [cnv3_pkg::POS_W-1:0]       o_out_col,
    output logic [cnv3_pkg::PIX_W-1:0]       o_out_value,
    output logic                             o_last_of_frame
);
    import cnv3_pkg::*;

    logic [KROW_W-1:0]     krows [3];
    t_pix                  kern [TAPS];
    logic [PROD_W-1:0]     r_prod [TAPS];
    logic                  r_s3_valid;
    t_meta                 r_s3_meta;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_s4_valid;
    t_meta                 r_s4_meta;
    logic [SCALED_W-1:0]   r_scaled;
    logic                  r_s5_valid;
    t_meta                 r_s5_meta;
    t_pix                  sat;
    t_pix                  r_fifo_value [FIFO_DEPTH];
    t_meta                 r_fifo_meta [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [CREDIT_W-1:0]   r_count, n_count;

    always_comb begin
        krows[0] = i_cfg.krow_top;
        krows[1] = i_cfg.krow_mid;
        krows[2] = i_cfg.krow_bot;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                kern[i*3+j] = krows[i][j*PIX_W +: PIX_W];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            sum = sum + SUM_W'(r_prod[k]);
        end
    end

    assign sat = (|r_scaled[SCALED_W-1:FRAC_W+PIX_W]) ? {PIX_W{1'b1}}
                                                      : r_scaled[FRAC_W +: PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TAPS; k++) begin
            r_prod[k] <= PROD_W'(kern[k]) * PROD_W'(i_win[k]);
        end
        r_s3_meta <= i_meta;
        r_sum     <= sum;
        r_s4_meta <= r_s3_meta;
        r_scaled  <= SCALED_W'(r_sum) * SCALED_W'(i_cfg.scale);
        r_s5_meta <= r_s4_meta;
        if (r_s5_valid) begin
            r_fifo_value[r_wr_ptr] <= sat;
            r_fifo_meta[r_wr_ptr]  <= r_s5_meta;
        end
    end

    assign o_valid = r_count != '0;
    assign o_pop   = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (r_s5_valid) begin
            n_count = n_count + CREDIT_W'(1);
        end
        if (o_pop) begin
            n_count = n_count - CREDIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (r_s5_valid) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + FIFO_AW'(1);
            end
            if (o_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    assign o_out_row       = r_fifo_meta[r_rd_ptr].row;
    assign o_out_col       = r_fifo_meta[r_rd_ptr].col;
    assign o_out_value     = r_fifo_value[r_rd_ptr];
    assign o_last_of_frame = r_fifo_meta[r_rd_ptr].last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_valid |-> (r_count < CREDIT_W'(FIFO_DEPTH)))
        else $error("result queue written while full");

endmodule

`default_nettype wire
